[rtl/core/afq_pkg.sv]
package afq_pkg;

  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;
  // Fixed-point sum: 50 fraction bits, integer part up to 2^10, plus sign.
  localparam int FRAC_W  = 50;
  localparam int SUM_W   = 61;
  localparam int MAG_W   = 60;
  localparam int PFIX_W  = 59;

  typedef enum logic [1:0] {
    REG_INV_SCALE  = 2'd0,
    REG_ZERO_POINT = 2'd1,
    REG_RESOLUTION = 2'd2
  } reg_idx_t;

  // Unpacked fp32 operand: normalized mantissa, unbiased exponent.
  typedef struct packed {
    logic              sgn;
    logic              spec;   // infinity or NaN
    logic              zero;
    logic [23:0]       mant;
    logic signed [9:0] exp;
  } fp_unp_t;

  function automatic logic [4:0] lzc24(input logic [23:0] v);
    logic [4:0] n;
    logic       found;
    n     = 5'd24;
    found = 1'b0;
    for (int i = 23; i >= 0; i--) begin
      if (!found && v[i]) begin
        n     = 5'(23 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

  function automatic logic [3:0] msb16(input logic [15:0] v);
    logic [3:0] p;
    p = 4'd0;
    for (int i = 0; i < 16; i++) begin
      if (v[i]) begin
        p = 4'(i);
      end
    end
    return p;
  endfunction

  function automatic fp_unp_t unpack(input logic [31:0] b);
    fp_unp_t    u;
    logic [4:0] lz;
    u.sgn  = b[31];
    u.spec = (b[30:23] == 8'hFF);
    u.zero = (b[30:0] == 31'd0);
    lz     = lzc24({1'b0, b[22:0]});
    if (b[30:23] == 8'd0) begin
      // subnormal: shift the leading one up to the hidden position
      u.mant = {1'b0, b[22:0]} << lz;
      u.exp  = -10'sd126 - $signed({5'd0, lz});
    end else begin
      u.mant = {1'b1, b[22:0]};
      u.exp  = $signed({2'b00, b[30:23]}) - 10'sd127;
    end
    return u;
  endfunction

endpackage

[rtl/core/affine_quantizer_fp32_to_u8.sv]
// Channel | Direction | Handshake          | Payload
// --------+-----------+--------------------+---------------------------
// in      | input     | in_valid/in_stall  | value_bits[31:0], is_last
// out     | output    | out_valid/out_stall| code[7:0], last_out
// cfg     | input     | APB (pready = 1)   | inv_scale, zero_point, resolution
//
// Eight register stages, output register included; one item per cycle sustained
// while out_stall is low. The 24x24 mantissa multiply and the 60-bit leading-one
// search (split over two stages) set the stage depth.
// rst clears the valid bits and loads the register reset values.
// Each stage loads whenever it is empty or the next one loads, so bubbles close
// up under out_stall and input is taken while a result waits at the output.
module affine_quantizer_fp32_to_u8 (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [31:0]                value_bits,
  input  logic                       is_last,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [7:0]                 code,
  output logic                       last_out,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [afq_pkg::ADDR_W-1:0] paddr,
  input  logic [afq_pkg::DATA_W-1:0] pwdata,
  output logic [afq_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import afq_pkg::*;

  localparam int NST = 8;

  // Configuration registers.
  logic [31:0] inv_scale;
  logic [7:0]  zero_point;
  logic [3:0]  resolution;
  reg_idx_t    cfg_sel;

  assign pready  = 1'b1;
  assign cfg_sel = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_scale  <= 32'h3F80_0000;
      zero_point <= 8'd0;
      resolution <= 4'd8;
    end else if (psel && penable && pwrite) begin
      case (cfg_sel)
        REG_INV_SCALE:  inv_scale  <= pwdata;
        REG_ZERO_POINT: zero_point <= pwdata[7:0];
        REG_RESOLUTION: resolution <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_INV_SCALE:  prdata = inv_scale;
      REG_ZERO_POINT: prdata = {24'd0, zero_point};
      REG_RESOLUTION: prdata = {28'd0, resolution};
      default:        prdata = '0;
    endcase
  end

  // Pipeline flow control: a stage loads when empty or when downstream loads.
  logic [NST-1:0] vld;
  logic [NST-1:0] ld;

  always_comb begin
    ld[NST-1] = !vld[NST-1] || !out_stall;
    for (int i = NST - 2; i >= 0; i--) begin
      ld[i] = !vld[i] || ld[i+1];
    end
  end

  assign in_stall  = !ld[0];
  assign out_valid = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (ld[0]) begin
        vld[0] <= in_valid;
      end
      for (int i = 1; i < NST; i++) begin
        if (ld[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // Stage 0: unpack both operands, normalize subnormal mantissas.
  fp_unp_t ux, us;
  assign ux = unpack(value_bits);
  assign us = unpack(inv_scale);

  logic              sgn0, spec0, zero0, last0;
  logic [23:0]       ma0, mb0;
  logic signed [9:0] ea0, eb0;

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      sgn0  <= ux.sgn ^ us.sgn;
      spec0 <= ux.spec || us.spec;
      zero0 <= ux.zero || us.zero;
      ma0   <= ux.mant;
      mb0   <= us.mant;
      ea0   <= ux.exp;
      eb0   <= us.exp;
      last0 <= is_last;
    end
  end

  // Stage 1: mantissa product and exponent sum.
  logic               sgn1, spec1, zero1, last1;
  logic [47:0]        prod1;
  logic signed [10:0] esum1;

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      prod1 <= ma0 * mb0;
      esum1 <= 11'(ea0) + 11'(eb0);
      sgn1  <= sgn0;
      spec1 <= spec0;
      zero1 <= zero0;
      last1 <= last0;
    end
  end

  // Stage 2: round the product to 24 bits, nearest even.
  logic               hi2, g2, st2, up2;
  logic [23:0]        mt2;
  logic [24:0]        mr2;
  logic signed [10:0] ex2;
  logic [23:0]        mant2;
  logic signed [10:0] ep2;
  logic               sgn2, spec2, zero2, last2;

  always_comb begin
    hi2 = prod1[47];
    mt2 = hi2 ? prod1[47:24] : prod1[46:23];
    g2  = hi2 ? prod1[23] : prod1[22];
    st2 = hi2 ? (|prod1[22:0]) : (|prod1[21:0]);
    ex2 = esum1 + $signed({10'd0, hi2});
    up2 = g2 && (st2 || mt2[0]);
    mr2 = {1'b0, mt2} + {24'd0, up2};
  end

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      if (mr2[24]) begin
        mant2 <= 24'h80_0000;
        ep2   <= ex2 + 11'sd1;
      end else begin
        mant2 <= mr2[23:0];
        ep2   <= ex2;
      end
      sgn2  <= sgn1;
      spec2 <= spec1;
      zero2 <= zero1;
      last2 <= last1;
    end
  end

  // Stage 3: classify the product and add the zero point in fixed point.
  // A product below 2^-26 cannot move the sum off the zero point.
  logic                f0_3n, f255_3n;
  logic [PFIX_W-1:0]   pfix;
  logic [5:0]          sh3;
  logic [31:0]         top3;
  logic [SUM_W-1:0]    zpx, px, sum3n;
  logic [SUM_W-1:0]    sum3;
  logic                f0_3, f255_3, last3;

  always_comb begin
    f0_3n   = 1'b0;
    f255_3n = 1'b0;
    pfix    = '0;
    sh3     = 6'(ep2 + 11'sd27);
    top3    = {1'b0, mant2, 7'd0} + {24'd0, zero_point};
    if (spec2) begin
      f0_3n = 1'b1;
    end else if (zero2 || ep2 < -11'sd26) begin
      pfix = '0;
    end else if (ep2 >= 11'sd31) begin
      f0_3n = 1'b1;
    end else if (ep2 >= 11'sd9) begin
      if (sgn2) begin
        f0_3n = 1'b1;
      end else if (ep2 == 11'sd30 && top3 >= 32'h7FFF_FFC0) begin
        // sum rounds up to 2^31: integer conversion overflows
        f0_3n = 1'b1;
      end else begin
        f255_3n = 1'b1;
      end
    end else begin
      pfix = {35'd0, mant2} << sh3;
    end
    zpx   = {3'd0, zero_point, 50'd0};
    px    = {2'd0, pfix};
    sum3n = sgn2 ? (zpx - px) : (zpx + px);
  end

  always_ff @(posedge clk) begin
    if (ld[3]) begin
      sum3   <= sum3n;
      f0_3   <= f0_3n;
      f255_3 <= f255_3n;
      last3  <= last2;
    end
  end

  // Stage 4: leading-one search, first level (16-bit chunks).
  logic [63:0]       pad4;
  logic [MAG_W-1:0]  mag4;
  logic [3:0]        nz4;
  logic [3:0][3:0]   pos4;
  logic              f0_4, f255_4, last4;

  assign pad4 = {4'd0, sum3[MAG_W-1:0]};

  always_ff @(posedge clk) begin
    if (ld[4]) begin
      mag4 <= sum3[MAG_W-1:0];
      for (int c = 0; c < 4; c++) begin
        nz4[c]  <= |pad4[16*c +: 16];
        pos4[c] <= msb16(pad4[16*c +: 16]);
      end
      // negative sum: code is zero
      f0_4   <= f0_3 || sum3[SUM_W-1];
      f255_4 <= f255_3;
      last4  <= last3;
    end
  end

  // Stage 5: leading-one search, second level.
  logic [5:0]       l5n;
  logic [MAG_W-1:0] mag5;
  logic [5:0]       l5;
  logic             f0_5, f255_5, last5;

  always_comb begin
    l5n = 6'd0;
    for (int c = 0; c < 4; c++) begin
      if (nz4[c]) begin
        l5n = {2'(c), pos4[c]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld[5]) begin
      mag5   <= mag4;
      l5     <= l5n;
      f0_5   <= f0_4;
      f255_5 <= f255_4;
      last5  <= last4;
    end
  end

  // Stage 6: round the sum to fp32 precision (24 significant bits).
  logic [5:0]       k6;
  logic [SUM_W-1:0] rm6, half6, mg6, tr6, sr6n;
  logic             gd6, st6, lsb6;
  logic [SUM_W-1:0] sr6;
  logic             f0_6, f255_6, last6;

  always_comb begin
    k6    = l5 - 6'd23;
    rm6   = SUM_W'(1) << k6;
    half6 = rm6 >> 1;
    mg6   = {1'b0, mag5};
    gd6   = |(mg6 & half6);
    st6   = |(mg6 & (half6 - SUM_W'(1)));
    lsb6  = |(mg6 & rm6);
    tr6   = mg6 & ~(rm6 - SUM_W'(1));
    if (l5 >= 6'd24) begin
      sr6n = tr6 + ((gd6 && (st6 || lsb6)) ? rm6 : '0);
    end else begin
      sr6n = mg6;
    end
  end

  always_ff @(posedge clk) begin
    if (ld[6]) begin
      sr6    <= sr6n;
      f0_6   <= f0_5;
      f255_6 <= f255_5;
      last6  <= last5;
    end
  end

  // Stage 7: round to integer (ties to even), saturate, clamp to resolution.
  localparam logic [SUM_W-1:0]  HALF_FX = SUM_W'(1) << (FRAC_W - 1);
  localparam logic [SUM_W-1:0]  MAX_FX  = SUM_W'(255) << FRAC_W;
  localparam logic [FRAC_W-1:0] HALF_FR = FRAC_W'(1) << (FRAC_W - 1);

  logic [7:0]        n7, c7, maxv7, code7;
  logic [FRAC_W-1:0] fr7;
  logic              up7;

  always_comb begin
    n7  = sr6[FRAC_W +: 8];
    fr7 = sr6[FRAC_W-1:0];
    up7 = (fr7 > HALF_FR) || (fr7 == HALF_FR && n7[0]);
    if (f0_6) begin
      c7 = 8'd0;
    end else if (f255_6) begin
      c7 = 8'd255;
    end else if (sr6 <= HALF_FX) begin
      c7 = 8'd0;
    end else if (sr6 >= MAX_FX) begin
      c7 = 8'd255;
    end else begin
      c7 = n7 + {7'd0, up7};
    end
    maxv7 = 8'((9'd1 << resolution[2:0]) - 9'd1);
    if (resolution < 4'd8 && c7 > maxv7) begin
      code7 = maxv7;
    end else begin
      code7 = c7;
    end
  end

  always_ff @(posedge clk) begin
    if (ld[7]) begin
      code     <= code7;
      last_out <= last6;
    end
  end

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import afq_pkg::*;

  localparam int MAX_SHOWN  = 10;
  localparam int IDLE_PCT   = 29;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 24;

  // Expected codes and the fp32 arithmetic that produces them. The simulator
  // computes in double precision, so every fp32 operation is done exactly in
  // double and then rounded to single precision by hand (nearest even,
  // subnormals kept, overflow to infinity).
  class quant_scoreboard;
    typedef struct {
      logic [7:0] code;
      logic       last;
    } code_item_t;

    bit [31:0]  inv_scale;
    bit [7:0]   zero_pt;
    bit [3:0]   res_bits;
    code_item_t pending[$];
    int         errors;

    function new();
      inv_scale = 32'h3F80_0000;
      zero_pt   = 8'd0;
      res_bits  = 4'd8;
      errors    = 0;
    endfunction

    static function real f32_to_real(bit [31:0] b);
      real r;
      if (b[30:23] == 8'hFF) begin
        r = $bitstoreal({b[31], 11'h7FF, b[22:0], 29'd0});
      end else if (b[30:23] == 8'd0) begin
        r = real'(b[22:0]) * 2.0 ** (-149);
        if (b[31]) r = -r;
      end else begin
        r = $bitstoreal({b[31], 11'(b[30:23] + 11'd896), b[22:0], 29'd0});
      end
      return r;
    endfunction

    static function bit is_nan(real x);
      bit [63:0] b;
      b = $realtobits(x);
      return (b[62:52] == 11'h7FF) && (b[51:0] != 52'd0);
    endfunction

    // Round a double to the nearest fp32 value, returned as a double.
    static function real round_f32(real x);
      bit [63:0] b;
      bit [63:0] m;
      bit [63:0] q;
      bit [63:0] rem;
      bit [63:0] half;
      int        e;
      int        d;
      real       r;
      b = $realtobits(x);
      if (b[62:52] == 11'h7FF || x == 0.0) return x;
      e = int'(b[62:52]) - 1023;
      m = {11'd0, 1'b1, b[51:0]};
      d = 29;
      if (e < -126) d = 29 + (-126 - e);
      if (d > 54) return 0.0;
      q    = m >> d;
      rem  = m & ((64'd1 << d) - 64'd1);
      half = 64'd1 << (d - 1);
      if (rem > half || (rem == half && q[0])) q = q + 64'd1;
      r = real'(q) * 2.0 ** (e - 52 + d);
      if (r >= 2.0 ** 128) r = $bitstoreal(64'h7FF0_0000_0000_0000);
      return b[63] ? -r : r;
    endfunction

    function bit [7:0] quantize(bit [31:0] v);
      real    prod;
      real    s;
      int     n;
      real    frac;
      bit [7:0] c;
      prod = round_f32(f32_to_real(v) * f32_to_real(inv_scale));
      s    = round_f32(prod + real'(zero_pt));
      // NaN and anything at or past 2^31 convert to the int32 minimum
      if (is_nan(s) || s >= 2.0 ** 31 || s <= 0.5) begin
        c = 8'd0;
      end else if (s >= 255.0) begin
        c = 8'd255;
      end else begin
        n    = $rtoi(s);
        frac = s - real'(n);
        if (frac > 0.5 || (frac == 0.5 && n[0])) n++;
        c = (n > 255) ? 8'd255 : 8'(n);
      end
      if (res_bits < 4'd8 && c > ((8'd1 << res_bits) - 8'd1)) c = (8'd1 << res_bits) - 8'd1;
      return c;
    endfunction

    function void note_input(bit [31:0] v, bit l);
      code_item_t it;
      it.code = quantize(v);
      it.last = l;
      pending.push_back(it);
    endfunction

    function void check_result(logic [7:0] c, logic l);
      code_item_t it;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= MAX_SHOWN) $display("unexpected item: code=%0d last=%0b", c, l);
        return;
      end
      it = pending.pop_front();
      if (c !== it.code || l !== it.last) begin
        errors++;
        if (errors <= MAX_SHOWN)
          $display("mismatch: code exp=%0d got=%0d, last exp=%0b got=%0b",
                   it.code, c, it.last, l);
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [31:0]        value_bits = '0;
  logic               is_last = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [7:0]         code;
  logic               last_out;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [ADDR_W-1:0]  paddr = '0;
  logic [DATA_W-1:0]  pwdata = '0;
  logic [DATA_W-1:0]  prdata;
  logic               pready;

  quant_scoreboard sb = new();
  bit              quiet = 1'b0;   // set to drop all idling on both sides
  int              idle_cycles = 0;

  affine_quantizer_fp32_to_u8 u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .value_bits(value_bits), .is_last(is_last),
    .out_valid(out_valid), .out_stall(out_stall), .code(code), .last_out(last_out),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #4 clk = ~clk;

  // Receiver: stall at random except during the quiet stretch.
  always @(negedge clk) begin
    out_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
  end

  // Check every item that leaves the block.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(code, last_out);
  end

  // Watchdog: count cycles in which neither channel moves an item.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Exact fp32 bit pattern of a normal (or zero) double; else random bits.
  function automatic bit [31:0] real_to_f32(real r);
    bit [63:0] b;
    b = $realtobits(r);
    if (r == 0.0) return 32'd0;
    if (b[62:52] < 11'd897 || b[62:52] > 11'd1150) return $urandom;
    return {b[63], 8'(b[62:52] - 11'd896), b[51:29]};
  endfunction

  // Write one register; hold psel through setup and access cycles.
  task automatic write_reg(reg_idx_t idx, bit [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= ADDR_W'(4 * int'(idx));
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_INV_SCALE:  sb.inv_scale = data;
      REG_ZERO_POINT: sb.zero_pt   = data[7:0];
      REG_RESOLUTION: sb.res_bits  = data[3:0];
      default: ;
    endcase
  endtask

  // Pause until every expected item has come back, then let the pipe settle.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic configure(bit [31:0] inv, bit [7:0] zp, bit [3:0] res);
    wait_drained();
    write_reg(REG_INV_SCALE, inv);
    write_reg(REG_ZERO_POINT, {24'd0, zp});
    write_reg(REG_RESOLUTION, {28'd0, res});
  endtask

  // Offer one item from a falling edge; note it when it is taken.
  task automatic send_item(bit [31:0] v, bit l);
    while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    value_bits <= v;
    is_last    <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(v, l);
    @(negedge clk);
  endtask

  // Mostly values that land inside the code range, ties included.
  function automatic bit [31:0] pick_value();
    int  roll;
    real sc;
    roll = $urandom_range(0, 99);
    sc   = quant_scoreboard::f32_to_real(sb.inv_scale);
    if (roll < 55 && sb.inv_scale[30:23] != 8'hFF && sb.inv_scale[30:23] != 8'd0)
      return real_to_f32(quant_scoreboard::round_f32(
        ($urandom_range(0, 620) / 2.0 - 30.0 - real'(sb.zero_pt)) / sc));
    if (roll < 80) return $urandom;
    if (roll < 92) return real_to_f32($urandom_range(0, 1200) / 2.0 - 300.0);
    case ($urandom_range(0, 5))
      0: return 32'h7F80_0000;
      1: return 32'hFF80_0000;
      2: return 32'h7FC0_0000 | $urandom_range(0, 255);
      3: return $urandom_range(0, 32'h007F_FFFF);
      4: return 32'h4F00_0000;
      default: return 32'h4EFF_FFFF;
    endcase
  endfunction

  task automatic random_items(int count);
    repeat (count) send_item(pick_value(), 1'($urandom_range(0, 1)));
  endtask

  initial begin
    bit [31:0] directed[$];
    directed = '{32'h0000_0000, 32'h8000_0000, 32'h3F00_0000, 32'h3FC0_0000,
                 32'h4020_0000, 32'h437E_8000, 32'h437F_8000, 32'h437F_0000,
                 32'h4380_0000, 32'h4F00_0000, 32'h4EFF_FFFF, 32'hBF80_0000,
                 32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000, 32'hFFFF_FFFF,
                 32'h0000_0001, 32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h3EFF_FFFF,
                 32'h3F00_0001, 32'h4160_0000, 32'hCF00_0001, 32'h3F80_0000};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings first: extremes and the special cases.
    foreach (directed[i]) send_item(directed[i], i[0]);

    // Quiet stretch: no idling on either side.
    quiet = 1'b1;
    random_items(150);
    quiet = 1'b0;

    configure(32'h3F00_0000, 8'd128, 4'd8);        // scale 0.5, mid zero point
    random_items(200);
    configure(32'h3F80_0000, 8'd255, 4'd4);
    random_items(150);
    configure(32'h4000_0000, 8'd0, 4'd1);
    random_items(150);
    configure(32'h3F80_0000, 8'd7, 4'd0);          // every code clamps to zero
    random_items(80);
    configure(32'h3F80_0000, 8'd3, 4'd15);         // no extra clamp
    random_items(120);
    configure(32'hFFFF_FFFF, 8'd10, 4'd8);         // NaN scale
    random_items(40);
    configure(32'h7F80_0000, 8'd10, 4'd8);         // infinite scale
    random_items(40);
    configure(32'h0000_0000, 8'd200, 4'd8);        // zero scale
    random_items(40);
    configure(32'h0000_0001, 8'd1, 4'd7);          // smallest subnormal scale
    random_items(40);

    // Random settings with a drain pause between each.
    repeat (8) begin
      configure(real_to_f32(quant_scoreboard::round_f32(
                  2.0 ** $urandom_range(0, 8) / 16.0 * (1.0 + $urandom / 4294967296.0))),
                8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)));
      random_items(100);
    end

    wait_drained();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      if (sb.pending.size() != 0) $display("%0d items never came out", sb.pending.size());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
